>>> rtl/ptr_ema_pkg.sv
package ptr_ema_pkg;

    localparam int PixW     = 16;
    localparam int FixW     = 32;
    localparam int GainW    = 17;
    localparam int ZoneW    = 16;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 17;
    localparam int ProdW    = FixW + GainW;

    localparam logic [GainW-1:0] GainOne   = 17'h10000;
    localparam logic [GainW-1:0] GainReset = 17'd7864;
    localparam logic [ZoneW-1:0] ZoneReset = 16'd410;
    localparam logic             EnReset   = 1'b1;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_GAIN   = 2'd0,
        CFG_ZONE   = 2'd1,
        CFG_ENABLE = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [PixW-1:0] raw_x;
        logic [PixW-1:0] raw_y;
    } pointer_in_t;

    typedef struct packed {
        logic [PixW-1:0] cursor_x;
        logic [PixW-1:0] cursor_y;
    } cursor_out_t;

    // One EMA step: move avg toward the sample by alpha, floor toward minus infinity.
    function automatic logic [FixW-1:0] ema_step(
        input logic [FixW-1:0]  avg,
        input logic [PixW-1:0]  raw,
        input logic [GainW-1:0] alpha
    );
        logic [FixW-1:0]  target;
        logic [FixW-1:0]  mag;
        logic [ProdW-1:0] prod;
        logic [FixW-1:0]  delta;
        target = {raw, 16'h0000};
        if (target >= avg) begin
            mag   = target - avg;
            prod  = ProdW'(mag) * ProdW'(alpha);
            delta = prod[FixW+15:16];
            return avg + delta;
        end else begin
            mag   = avg - target;
            prod  = ProdW'(mag) * ProdW'(alpha) + ProdW'(16'hFFFF);
            delta = prod[FixW+15:16];
            return avg - delta;
        end
    endfunction

    function automatic logic within_zone(
        input logic [FixW-1:0]  a,
        input logic [FixW-1:0]  b,
        input logic [ZoneW-1:0] zone
    );
        logic [FixW-1:0] span;
        span = (a >= b) ? (a - b) : (b - a);
        return span < {8'h00, zone, 8'h00};
    endfunction

    // Round half-up to whole pixels.
    function automatic logic [PixW-1:0] to_pixel(input logic [FixW-1:0] v);
        logic [FixW:0] sum;
        sum = {1'b0, v} + (FixW+1)'(16'h8000);
        return sum[FixW-1:16];
    endfunction

endpackage

>>> rtl/pointer_ema_deadzone_smoother_top.sv
// Channel   | Handshake              | Payload
// ----------+------------------------+-------------------------------------
// input     | s_valid / s_ready      | s_data   (raw_x, raw_y)
// result    | m_valid / m_ready      | m_data   (cursor_x, cursor_y)
// config    | cfg_valid / cfg_ready  | cfg_index, cfg_data (always ready)
//
// One beat per cycle sustained while the result side keeps taking beats. An accepted
// beat waits in the input register; once the result register is free, the EMA multiply-add,
// deadzone compare and rounding for both axes run on it and load the result register,
// which raises m_valid. A beat inside the deadzone leaves no result.
// Synchronous active-low reset clears the averages, the primed flag and the registers'
// valid bits. A stalled result holds the input register, and s_ready drops only while
// both registers are full and m_ready is low.
module pointer_ema_deadzone_smoother_top
    import ptr_ema_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pointer_in_t         s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output cursor_out_t         m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data
);

    logic [GainW-1:0] gain_reg;
    logic [ZoneW-1:0] zone_reg;
    logic             enable_reg;

    logic [FixW-1:0]  avg_x_reg, avg_x_next;
    logic [FixW-1:0]  avg_y_reg, avg_y_next;
    logic [FixW-1:0]  emit_x_reg, emit_x_next;
    logic [FixW-1:0]  emit_y_reg, emit_y_next;
    logic             primed_reg, primed_next;

    logic             in_valid_reg;
    pointer_in_t      in_data_reg;
    logic             out_valid_reg, out_valid_next;
    cursor_out_t      out_data_reg, out_data_next;

    logic             out_free;
    logic             advance;
    logic [GainW-1:0] alpha;
    logic [FixW-1:0]  upd_x, upd_y;
    logic             emit;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_ready;
    assign advance   = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || out_free;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    assign alpha = (gain_reg > GainOne) ? GainOne : gain_reg;
    assign upd_x = ema_step(avg_x_reg, in_data_reg.raw_x, alpha);
    assign upd_y = ema_step(avg_y_reg, in_data_reg.raw_y, alpha);

    always_comb begin
        avg_x_next    = avg_x_reg;
        avg_y_next    = avg_y_reg;
        emit_x_next   = emit_x_reg;
        emit_y_next   = emit_y_reg;
        primed_next   = primed_reg;
        emit          = 1'b1;
        out_data_next = '{cursor_x: in_data_reg.raw_x, cursor_y: in_data_reg.raw_y};
        if (!enable_reg) begin
            // pass through, state untouched
        end else if (!primed_reg) begin
            avg_x_next  = {in_data_reg.raw_x, 16'h0000};
            avg_y_next  = {in_data_reg.raw_y, 16'h0000};
            emit_x_next = {in_data_reg.raw_x, 16'h0000};
            emit_y_next = {in_data_reg.raw_y, 16'h0000};
            primed_next = 1'b1;
        end else begin
            avg_x_next = upd_x;
            avg_y_next = upd_y;
            if (within_zone(upd_x, emit_x_reg, zone_reg) &&
                within_zone(upd_y, emit_y_reg, zone_reg)) begin
                emit = 1'b0;
            end else begin
                emit_x_next   = upd_x;
                emit_y_next   = upd_y;
                out_data_next = '{cursor_x: to_pixel(upd_x), cursor_y: to_pixel(upd_y)};
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = emit;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg   <= GainReset;
            zone_reg   <= ZoneReset;
            enable_reg <= EnReset;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_GAIN:   gain_reg   <= cfg_data;
                CFG_ZONE:   zone_reg   <= cfg_data[ZoneW-1:0];
                CFG_ENABLE: enable_reg <= cfg_data[0];
                default: ; // drop writes to unused indexes
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            avg_x_reg     <= '0;
            avg_y_reg     <= '0;
            emit_x_reg    <= '0;
            emit_y_reg    <= '0;
            primed_reg    <= 1'b0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                avg_x_reg  <= avg_x_next;
                avg_y_reg  <= avg_y_next;
                emit_x_reg <= emit_x_next;
                emit_y_reg <= emit_y_next;
                primed_reg <= primed_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance && emit) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

>>> rtl/ptr_ema_checker.sv
module ptr_ema_checker
    import ptr_ema_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input cursor_out_t         m_data
);

    // A stalled result beat holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // A taken result frees room, so the input side must be open.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while result side drains");

    // A fresh result must stem from an accepted input beat.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result without a matching input beat");

    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind pointer_ema_deadzone_smoother_top ptr_ema_checker u_ptr_ema_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data)
);

>>> sim/testbench.sv
module testbench;
    import ptr_ema_pkg::*;

    localparam int CycleLimit   = 800000;
    localparam int SettleCycles = 4;
    localparam int PhaseCount   = 8;
    localparam int PhaseItems   = 131;

    localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;

    typedef enum logic [1:0] {
        FIX_NONE,
        FIX_EMIT,
        FIX_SILENT
    } fix_kind_t;

    typedef struct {
        bit                  is_write;
        logic [CfgIdxW-1:0]  reg_index;
        logic [CfgDataW-1:0] reg_value;
        pointer_in_t         point;
        fix_kind_t           fix;
        cursor_out_t         cursor;
    } stim_row_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    pointer_in_t         s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    cursor_out_t         m_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data = '0;

    // travel with s_data: a hand-typed expectation for the current beat, if any
    fix_kind_t   row_fix = FIX_NONE;
    cursor_out_t row_cursor = '0;

    // smoother state as the testbench sees it
    logic [GainW-1:0] gain_reg;
    logic [ZoneW-1:0] zone_reg;
    logic             smooth_en;
    logic [FixW-1:0]  avg_x, avg_y;
    logic [FixW-1:0]  mark_x, mark_y;
    bit               primed;

    cursor_out_t expected_cursor[$];
    stim_row_t   directed_plan[$];

    int errors = 0;
    int items_sent = 0;
    int results_seen = 0;
    int silent_items = 0;
    int cfg_writes = 0;
    int cycle_count = 0;
    int aim_x = 0;
    int aim_y = 0;
    bit burst_mode = 1'b0;

    pointer_ema_deadzone_smoother_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $error("timed out after %0d cycles, %0d cursor beats outstanding",
                   cycle_count, expected_cursor.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------- predictor ----------------

    function automatic logic [FixW-1:0] ema_next(input logic [FixW-1:0] avg,
                                                  input logic [PixW-1:0] raw);
        logic [GainW-1:0]      alpha;
        logic [FixW-1:0]       goal;
        logic [FixW+GainW-1:0] prod;
        alpha = (gain_reg > GainOne) ? GainOne : gain_reg;
        goal  = {raw, 16'h0000};
        if (goal >= avg) begin
            prod = (FixW+GainW)'(goal - avg) * (FixW+GainW)'(alpha);
            return avg + prod[FixW+15:16];
        end
        // moving down: round the step up so the average floors
        prod = (FixW+GainW)'(avg - goal) * (FixW+GainW)'(alpha) + (FixW+GainW)'(17'h0FFFF);
        return avg - prod[FixW+15:16];
    endfunction

    function automatic bit near_mark(input logic [FixW-1:0] a, input logic [FixW-1:0] b);
        logic [FixW-1:0] span;
        span = (a >= b) ? a - b : b - a;
        return span < (FixW'(zone_reg) << 8);
    endfunction

    function automatic logic [PixW-1:0] round_px(input logic [FixW-1:0] v);
        return PixW'(v[FixW-1:16] + PixW'(v[15]));
    endfunction

    task automatic run_smoother(input pointer_in_t p, output bit emits,
                                output cursor_out_t c);
        emits      = 1'b1;
        c.cursor_x = p.raw_x;
        c.cursor_y = p.raw_y;
        if (!smooth_en)
            return;
        if (!primed) begin
            avg_x  = {p.raw_x, 16'h0000};
            avg_y  = {p.raw_y, 16'h0000};
            mark_x = avg_x;
            mark_y = avg_y;
            primed = 1'b1;
            return;
        end
        avg_x = ema_next(avg_x, p.raw_x);
        avg_y = ema_next(avg_y, p.raw_y);
        if (near_mark(avg_x, mark_x) && near_mark(avg_y, mark_y)) begin
            emits = 1'b0;
            return;
        end
        mark_x     = avg_x;
        mark_y     = avg_y;
        c.cursor_x = round_px(avg_x);
        c.cursor_y = round_px(avg_y);
    endtask

    function automatic void check_field(input string name, input logic [PixW-1:0] want,
                                        input logic [PixW-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // ---------------- monitor and scoreboard ----------------

    always @(posedge aclk) begin : monitor
        bit          emits;
        cursor_out_t predicted;
        cursor_out_t want;
        if (!aresetn) begin
            gain_reg  = GainReset;
            zone_reg  = ZoneReset;
            smooth_en = EnReset;
            avg_x     = '0;
            avg_y     = '0;
            mark_x    = '0;
            mark_y    = '0;
            primed    = 1'b0;
            expected_cursor.delete();
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_cursor.size() == 0) begin
                    $error("unexpected cursor beat x=%0d y=%0d",
                           m_data.cursor_x, m_data.cursor_y);
                    errors++;
                end else begin
                    want = expected_cursor.pop_front();
                    check_field("cursor_x", want.cursor_x, m_data.cursor_x);
                    check_field("cursor_y", want.cursor_y, m_data.cursor_y);
                end
            end
            if (cfg_valid && cfg_ready) begin
                cfg_writes++;
                case (cfg_index)
                    CFG_GAIN:   gain_reg = cfg_data[GainW-1:0];
                    CFG_ZONE:   zone_reg = cfg_data[ZoneW-1:0];
                    CFG_ENABLE: smooth_en = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                run_smoother(s_data, emits, predicted);
                if (!emits)
                    silent_items++;
                if (row_fix == FIX_EMIT)
                    expected_cursor.push_back(row_cursor);
                else if (row_fix == FIX_NONE && emits)
                    expected_cursor.push_back(predicted);
            end
        end
    end

    // ---------------- result-side backpressure ----------------

    always @(posedge aclk) begin : sink
        int ready_left;
        int pick;
        if (!aresetn) begin
            m_ready <= 1'b0;
            ready_left = 0;
        end else if (ready_left == 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                m_ready <= 1'b1;
                ready_left = $urandom_range(1, 40);
            end else if (pick < 90) begin
                m_ready <= 1'b0;
                ready_left = $urandom_range(1, 3);
            end else begin
                m_ready <= 1'b0;
                ready_left = $urandom_range(15, 60);
            end
        end else begin
            ready_left--;
        end
    end

    // ---------------- stimulus ----------------

    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (burst_mode || pick < 50)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int clamp_px(input int v);
        return (v < 0) ? 0 : ((v > 65535) ? 65535 : v);
    endfunction

    function automatic int corner_px();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 65535;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    // Mostly jitter and drift around a held aim point, with jumps and corners.
    function automatic pointer_in_t next_point();
        pointer_in_t p;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            aim_x += int'($urandom_range(0, 6)) - 3;
            aim_y += int'($urandom_range(0, 6)) - 3;
        end else if (pick < 80) begin
            aim_x += int'($urandom_range(0, 128)) - 64;
            aim_y += int'($urandom_range(0, 128)) - 64;
        end else if (pick < 92) begin
            aim_x = $urandom_range(0, 65535);
            aim_y = $urandom_range(0, 65535);
        end else begin
            aim_x = corner_px();
            aim_y = corner_px();
        end
        aim_x   = clamp_px(aim_x);
        aim_y   = clamp_px(aim_y);
        p.raw_x = PixW'(aim_x);
        p.raw_y = PixW'(aim_y);
        return p;
    endfunction

    function automatic void add_point(input logic [PixW-1:0] x, input logic [PixW-1:0] y,
                                      input fix_kind_t fix = FIX_NONE,
                                      input logic [PixW-1:0] cx = '0,
                                      input logic [PixW-1:0] cy = '0);
        stim_row_t r;
        r.is_write  = 1'b0;
        r.reg_index = '0;
        r.reg_value = '0;
        r.point     = '{x, y};
        r.fix       = fix;
        r.cursor    = '{cx, cy};
        directed_plan.push_back(r);
    endfunction

    function automatic void add_write(input logic [CfgIdxW-1:0] idx,
                                      input logic [CfgDataW-1:0] value);
        stim_row_t r;
        r.is_write  = 1'b1;
        r.reg_index = idx;
        r.reg_value = value;
        r.point     = '0;
        r.fix       = FIX_NONE;
        r.cursor    = '0;
        directed_plan.push_back(r);
    endfunction

    task automatic send_point(input pointer_in_t p, input fix_kind_t fix,
                              input cursor_out_t want);
        int gap;
        gap = pick_gap();
        s_valid    <= 1'b1;
        s_data     <= p;
        row_fix    <= fix;
        row_cursor <= want;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Hold off until no result is owed and the pipeline has emptied.
    task automatic drain_block();
        s_valid <= 1'b0;
        repeat (SettleCycles) @(posedge aclk);
        while (expected_cursor.size() != 0)
            @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx,
                             input logic [CfgDataW-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [CfgDataW-1:0] pick_gain();
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return CfgDataW'(GainOne);
            2:       return 17'h1FFFF;
            3:       return CfgDataW'($urandom_range(1, 65535));
            4:       return CfgDataW'($urandom_range(65537, 17'h1FFFF));
            default: return CfgDataW'($urandom_range(2000, 20000));
        endcase
    endfunction

    function automatic logic [CfgDataW-1:0] pick_zone();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return 17'd65535;
            2:       return CfgDataW'($urandom_range(0, 65535));
            default: return CfgDataW'($urandom_range(50, 800));
        endcase
    endfunction

    initial begin
        pointer_in_t p;

        // first beat after reset primes and passes through; a repeat stays put
        add_point(16'd100, 16'd200, FIX_EMIT, 16'd100, 16'd200);
        add_point(16'd100, 16'd200, FIX_SILENT);
        add_point(16'd0, 16'd0);
        add_point(16'd65535, 16'd65535);
        add_point(16'd65535, 16'd0);
        // smoothing off: raw position straight through
        add_write(CFG_ENABLE, '0);
        add_point(16'd0, 16'd65535, FIX_EMIT, 16'd0, 16'd65535);
        add_point(16'd65535, 16'd0, FIX_EMIT, 16'd65535, 16'd0);
        add_point(16'h5A5A, 16'hA5A5, FIX_EMIT, 16'h5A5A, 16'hA5A5);
        // unity gain lands exactly on the sample
        add_write(CFG_GAIN, CfgDataW'(GainOne));
        add_write(CFG_ENABLE, 17'd1);
        add_point(16'd300, 16'd400);
        add_point(16'd300, 16'd400, FIX_SILENT);
        // gain above one saturates to unity
        add_write(CFG_GAIN, 17'h1FFFF);
        add_point(16'd1000, 16'd2000);
        add_point(16'd1000, 16'd2000, FIX_SILENT);
        // zero deadzone emits every smoothed beat
        add_write(CFG_ZONE, '0);
        add_point(16'd1000, 16'd2000, FIX_EMIT, 16'd1000, 16'd2000);
        add_point(16'd7, 16'd9, FIX_EMIT, 16'd7, 16'd9);
        // zero gain freezes the average
        add_write(CFG_GAIN, '0);
        add_point(16'd65535, 16'd65535, FIX_EMIT, 16'd7, 16'd9);
        // half gain lands on half pixels: exercises round half-up
        add_write(CFG_GAIN, 17'd32768);
        add_point(16'd8, 16'd10);
        add_write(CfgSpare, '0);
        add_point(16'd0, 16'd0);
        add_write(CFG_ZONE, 17'd65535);
        add_point(16'd65535, 16'd65535);
        add_point(16'd0, 16'd0);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_plan[i]) begin
            if (directed_plan[i].is_write) begin
                drain_block();
                write_reg(directed_plan[i].reg_index, directed_plan[i].reg_value);
            end else begin
                send_point(directed_plan[i].point, directed_plan[i].fix,
                           directed_plan[i].cursor);
            end
        end

        for (int phase = 0; phase < PhaseCount; phase++) begin
            drain_block();
            write_reg(CFG_GAIN, pick_gain());
            write_reg(CFG_ZONE, pick_zone());
            write_reg(CFG_ENABLE, CfgDataW'($urandom_range(0, 7) != 0));
            burst_mode = (phase % 3 == 2);
            for (int n = 0; n < PhaseItems; n++) begin
                p = next_point();
                send_point(p, FIX_NONE, '0);
                if (n == PhaseItems / 2 && phase % 2 == 1)
                    drain_block();
            end
        end

        drain_block();
        $display("Sent %0d pointer beats (%0d held inside the deadzone), checked %0d cursor beats,",
                 items_sent, silent_items, results_seen);
        $display("over %0d register writes covering pass-through, gain and deadzone extremes.",
                 cfg_writes);
        if (errors == 0 && expected_cursor.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
